// ===== rtl/gvd_pkg.sv =====
// Shared types, register indexes and per-channel arithmetic of the gradient pixel unit.
`default_nettype none

package gvd_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_CANVAS_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_CANVAS_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_TOP_RED       = 3'd2;
  localparam logic [2:0] CFG_TOP_GREEN     = 3'd3;
  localparam logic [2:0] CFG_TOP_BLUE      = 3'd4;
  localparam logic [2:0] CFG_BOTTOM_RED    = 3'd5;
  localparam logic [2:0] CFG_BOTTOM_GREEN  = 3'd6;
  localparam logic [2:0] CFG_BOTTOM_BLUE   = 3'd7;

  localparam int unsigned CfgDataW  = 11;
  localparam int unsigned CoordW    = 10;
  localparam int unsigned LinW      = 9;   // vertical weight 0..256
  localparam int unsigned FactW     = 9;   // vignette factor 0..256
  localparam int unsigned ChanW     = 16;  // 8.8 channel value
  localparam int unsigned NumChan   = 3;

  localparam logic [FactW-1:0] FactUnity = 9'd256;

  // 4x4 ordered dither thresholds, [row & 3][column & 3]
  localparam logic [3:0] BAYER [4][4] = '{
    '{4'd0,  4'd8,  4'd2,  4'd10},
    '{4'd12, 4'd4,  4'd14, 4'd6},
    '{4'd3,  4'd11, 4'd1,  4'd9},
    '{4'd15, 4'd7,  4'd13, 4'd5}
  };

  // Per-item side information carried along the pipe
  typedef struct packed {
    logic             off;
    logic             lin_zero;
    logic             col_en;
    logic [FactW-1:0] rs;
    logic [FactW-1:0] cs;
    logic [3:0]       bayer;
  } gvd_side_t;

  // top*256 + (bot - top)*wgt, floored at zero
  function automatic logic [ChanW-1:0] blend_chan(input logic [7:0] top,
                                                  input logic [7:0] bot,
                                                  input logic [LinW-1:0] wgt);
    logic signed [19:0] diff;
    logic signed [19:0] prod;
    logic signed [19:0] acc;
    diff = $signed({12'b0, bot}) - $signed({12'b0, top});
    prod = diff * $signed({11'b0, wgt});
    acc  = $signed({4'b0, top, 8'b0}) + prod;
    if (acc < 0) begin
      return '0;
    end else if (acc > 20'sd65535) begin
      return '1;
    end
    return acc[ChanW-1:0];
  endfunction

  // (v * f) >> 8, f at most 256 so the result stays in 16 bits
  function automatic logic [ChanW-1:0] scale_chan(input logic [ChanW-1:0] v,
                                                  input logic [FactW-1:0] f);
    logic [24:0] p;
    p = 25'(v) * 25'(f);
    return p[23:8];
  endfunction

  // Add dither bias, round, clamp to 0..255
  function automatic logic [7:0] quant_chan(input logic [ChanW-1:0] v,
                                            input logic [3:0] t,
                                            input logic six_bit);
    logic signed [19:0] bias;
    logic signed [19:0] s;
    if (six_bit) begin
      bias = $signed({10'b0, t, 6'b0}) - 20'sd480;
    end else begin
      bias = $signed({9'b0, t, 7'b0}) - 20'sd960;
    end
    s = $signed({4'b0, v}) + bias + 20'sd128;
    if (s < 20'sd256) begin
      return '0;
    end else if (s[19:8] > 12'd255) begin
      return 8'd255;
    end
    return s[15:8];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gradient_vignette_dither_pixel_unit.sv =====
// Pipelined RGB565 gradient background generator with vignette and ordered dither.
//
// Input channel: in_valid_i/in_ready_o carry one pixel coordinate (column_i, row_i).
// Output channel: out_valid_o/out_ready_i carry the pixel (pixel_o) and the
// off_canvas_o flag; off-canvas coordinates give pixel 0.
// Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i;
// write only while no item is in flight.
// Throughput: one item per clock while the output is not held. The 9 stages are
// input prep, three stages of a restoring divider (3 quotient bits each) for the
// vertical position, weight square, blend, row vignette multiply, column
// vignette multiply, and dither/pack into the output register.
// The whole pipe advances together: when the output is held (out_valid_o high,
// out_ready_i low) every stage holds and in_ready_o drops; bubbles keep moving
// otherwise, and no item is lost or repeated.
// Reset clears all valid bits and loads the registers with width 240,
// height 240 and black top and bottom colors.
`default_nettype none

module gradient_vignette_dither_pixel_unit
  import gvd_pkg::*;
#(
  parameter int unsigned EDGE_BAND = 40,
  parameter int unsigned MAX_DIM   = 1024
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire logic [CoordW-1:0]   column_i,
  input  wire logic [CoordW-1:0]   row_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic [15:0]         pixel_o,
  output      logic                off_canvas_o
);

  localparam int unsigned DW   = $clog2(MAX_DIM + 1);
  localparam int unsigned PW   = (DW > CoordW) ? DW : CoordW;
  localparam int unsigned LW   = (DW > CfgDataW) ? DW : CfgDataW;
  localparam int unsigned VW   = (EDGE_BAND > 1) ? $clog2(EDGE_BAND) : 1;
  localparam int unsigned RW   = CoordW + 8;
  localparam int unsigned CW   = PW + LinW;
  localparam int unsigned NStg = 9;

  // ---------------------------------------------------------------- registers
  logic [CfgDataW-1:0] width_q, height_q;
  logic [7:0]          top_q [NumChan];
  logic [7:0]          bot_q [NumChan];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd240;
      height_q <= 11'd240;
      for (int c = 0; c < NumChan; c++) begin
        top_q[c] <= '0;
        bot_q[c] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CANVAS_WIDTH:  width_q  <= cfg_data_i;
        CFG_CANVAS_HEIGHT: height_q <= cfg_data_i;
        CFG_TOP_RED:       top_q[0] <= cfg_data_i[7:0];
        CFG_TOP_GREEN:     top_q[1] <= cfg_data_i[7:0];
        CFG_TOP_BLUE:      top_q[2] <= cfg_data_i[7:0];
        CFG_BOTTOM_RED:    bot_q[0] <= cfg_data_i[7:0];
        CFG_BOTTOM_GREEN:  bot_q[1] <= cfg_data_i[7:0];
        CFG_BOTTOM_BLUE:   bot_q[2] <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Dimensions saturated to MAX_DIM
  logic [PW-1:0] w_e, h_e, dvs;
  assign w_e = (LW'(width_q) > LW'(MAX_DIM)) ? PW'(MAX_DIM) : PW'(width_q);
  assign h_e = (LW'(height_q) > LW'(MAX_DIM)) ? PW'(MAX_DIM) : PW'(height_q);
  assign dvs = h_e - PW'(1);

  // Edge factor table: floor(256*(0.52 + 0.48*a*(2-a))), a = d/EDGE_BAND
  logic [FactW-1:0] vig_tab [EDGE_BAND];
  for (genvar i = 0; i < EDGE_BAND; i++) begin : g_vig
    localparam int unsigned VigVal =
      (13312 * EDGE_BAND * EDGE_BAND + 12288 * i * (2 * EDGE_BAND - i)) /
      (100 * EDGE_BAND * EDGE_BAND);
    assign vig_tab[i] = FactW'(VigVal);
  end

  // ---------------------------------------------------------------- pipe control
  logic            en;
  logic [NStg:1]   vld_q;

  assign en          = !vld_q[NStg] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NStg];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-1:1], in_valid_i};
    end
  end

  // ---------------------------------------------------------------- stage 1: prep
  logic [PW-1:0]    x_e, y_e, mir_x, mir_y, dx, dy, half_w, edge_w;
  logic [FactW-1:0] rs_c, cs_c;
  gvd_side_t        side_d;
  gvd_side_t        side_q [1:8];
  logic [RW-1:0]    rem1_q;

  always_comb begin
    x_e    = PW'(column_i);
    y_e    = PW'(row_i);
    mir_x  = w_e - PW'(1) - x_e;
    mir_y  = h_e - PW'(1) - y_e;
    dx     = (x_e < mir_x) ? x_e : mir_x;
    dy     = (y_e < mir_y) ? y_e : mir_y;
    half_w = w_e >> 1;
    edge_w = (half_w < PW'(EDGE_BAND)) ? half_w : PW'(EDGE_BAND);
    rs_c   = (dy < PW'(EDGE_BAND)) ? vig_tab[dy[VW-1:0]] : FactUnity;
    cs_c   = (dx < PW'(EDGE_BAND)) ? vig_tab[dx[VW-1:0]] : FactUnity;

    side_d.off      = (x_e >= w_e) || (y_e >= h_e);
    side_d.lin_zero = (h_e <= PW'(1));
    side_d.col_en   = (x_e < edge_w) || (x_e >= w_e - edge_w);
    side_d.rs       = rs_c;
    side_d.cs       = cs_c;
    side_d.bayer    = BAYER[row_i[1:0]][column_i[1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[1] <= side_d;
      rem1_q    <= {row_i, 8'b0};
      for (int k = 2; k <= 8; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- stages 2-4: divider
  // Restoring division row*256 / (height-1), three quotient bits per stage.
  function automatic logic [RW+LinW-1:0] div_steps(input logic [RW-1:0] rem,
                                                   input logic [LinW-1:0] q,
                                                   input logic [PW-1:0] d,
                                                   input int top);
    logic [RW-1:0]   r;
    logic [LinW-1:0] qq;
    logic [CW-1:0]   cand;
    r  = rem;
    qq = q;
    for (int j = 0; j < 3; j++) begin
      cand = CW'(d) << (top - j);
      if (CW'(r) >= cand) begin
        r = r - RW'(cand);
        qq[top-j] = 1'b1;
      end
    end
    return {r, qq};
  endfunction

  logic [RW+LinW-1:0] div2_c, div3_c, div4_c;
  logic [RW-1:0]      rem2_q, rem3_q;
  logic [LinW-1:0]    q2_q, q3_q, lin4_q;

  assign div2_c = div_steps(rem1_q, '0, dvs, 8);
  assign div3_c = div_steps(rem2_q, q2_q, dvs, 5);
  assign div4_c = div_steps(rem3_q, q3_q, dvs, 2);

  always_ff @(posedge clk_i) begin
    if (en) begin
      {rem2_q, q2_q} <= div2_c;
      {rem3_q, q3_q} <= div3_c;
      lin4_q         <= div4_c[LinW-1:0];
    end
  end

  // ---------------------------------------------------------------- stage 5: square
  logic [17:0]     lin_sq;
  logic [LinW-1:0] wgt5_q;

  assign lin_sq = 18'(lin4_q) * 18'(lin4_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      wgt5_q <= side_q[4].lin_zero ? '0 : lin_sq[16:8];
    end
  end

  // ---------------------------------------------------------------- stages 6-9
  logic [ChanW-1:0] ch6_q [NumChan];
  logic [ChanW-1:0] ch7_q [NumChan];
  logic [ChanW-1:0] ch8_q [NumChan];
  logic [7:0]       lvl   [NumChan];
  logic [15:0]      pixel_q;
  logic             off_q;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      lvl[c] = quant_chan(ch8_q[c], side_q[8].bayer, (c == 1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < NumChan; c++) begin
        ch6_q[c] <= blend_chan(top_q[c], bot_q[c], wgt5_q);
        ch7_q[c] <= scale_chan(ch6_q[c], side_q[6].rs);
        ch8_q[c] <= side_q[7].col_en ? scale_chan(ch7_q[c], side_q[7].cs) : ch7_q[c];
      end
      off_q   <= side_q[8].off;
      pixel_q <= side_q[8].off ? 16'd0 : {lvl[0][7:3], lvl[1][7:2], lvl[2][7:3]};
    end
  end

  assign pixel_o      = pixel_q;
  assign off_canvas_o = off_q;

  // ---------------------------------------------------------------- assertions
  a_off_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && off_canvas_o |-> pixel_o == 16'd0)
    else $error("off-canvas item with nonzero pixel");

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[1])
    else $error("accepted item did not enter the pipe");

  a_stall_only_on_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  a_hold_freezes_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(vld_q))
    else $error("pipe moved while output held");

endmodule

`default_nettype wire
